@@ hw/rtl/mie_pkg.sv @@
// ----------------------------------------------------------------------------
// mie_pkg: shared definitions for the modular inverse unit
// Holds the default operand width, the modulus reset value, the sequencer
// state type and the control and status structs of the shared step unit.
// ----------------------------------------------------------------------------
package mie_pkg;

    localparam int WIDTH_DEFAULT = 16;
    localparam int MODULUS_RESET = 2048;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOP,
        ST_DIV,
        ST_FINISH
    } mie_state_t;

    typedef struct packed {
        logic start;
    } step_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } step_stat_t;

endpackage

@@ hw/rtl/mie_if.sv @@
// ----------------------------------------------------------------------------
// mie_if: channel interfaces of the modular inverse unit
// Operand request channel, result channel and modulus configuration channel,
// each a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface mie_req_if
    import mie_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] operand;

    modport source (output valid, output operand, input ready);
    modport sink   (input valid, input operand, output ready);
endinterface

interface mie_rsp_if
    import mie_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] inverse;
    logic             no_inverse;

    modport source (output valid, output inverse, output no_inverse, input ready);
    modport sink   (input valid, input inverse, input no_inverse, output ready);
endinterface

interface mie_cfg_if
    import mie_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] modulus;

    modport source (output valid, output modulus, input ready);
    modport sink   (input valid, input modulus, output ready);
endinterface

@@ hw/rtl/mie_step_unit.sv @@
// ----------------------------------------------------------------------------
// mie_step_unit: shared divide and multiply-accumulate step unit
// Restoring division producing one quotient bit per cycle, while the same
// quotient bit accumulates quotient times coefficient in Horner form.
// ----------------------------------------------------------------------------
module mie_step_unit
    import mie_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  step_ctrl_t              ctrl,
    input  logic [WIDTH-1:0]        dividend,
    input  logic [WIDTH-1:0]        divisor,
    input  logic signed [WIDTH+1:0] coef,
    output step_stat_t              stat,
    output logic [WIDTH-1:0]        remainder,
    output logic signed [WIDTH+1:0] product
);

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [WIDTH-1:0]        rem_reg, rem_next;
    logic [WIDTH-1:0]        dvd_reg, dvd_next;
    logic [WIDTH-1:0]        dsr_reg, dsr_next;
    logic signed [WIDTH+1:0] coef_reg, coef_next;
    logic signed [WIDTH+1:0] prod_reg, prod_next;

    logic [WIDTH:0]          shifted;
    logic [WIDTH+1:0]        diff;
    logic                    qbit;

    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[WIDTH-1]};
        diff      = {1'b0, shifted} - {2'b00, dsr_reg};
        qbit      = ~diff[WIDTH+1];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        coef_next = coef_reg;
        prod_next = prod_reg;

        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            coef_next = coef;
            prod_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            dvd_next  = {dvd_reg[WIDTH-2:0], 1'b0};
            prod_next = (prod_reg <<< 1) + (qbit ? coef_reg : '0);
            cnt_next  = cnt_reg + CW'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        coef_reg <= coef_next;
        prod_reg <= prod_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;
    assign product   = prod_reg;

endmodule

@@ hw/rtl/modular_inverse_ext_euclid_unit.sv @@
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_unit: modular inverse by extended Euclid
// Takes one operand per transaction on req and returns its inverse modulo
// the configured modulus on rsp, with a flag when no inverse exists.
//
// The modulus is written through the cfg channel, which is always ready; it
// must only be written while the unit is idle. Reset sets it to 2048 and
// clears the sequencer and the result valid.
// One operand transaction is accepted when req.ready is high, which is the
// case only while the sequencer is idle. Each Euclid step runs through the
// shared step unit, which yields one quotient bit per cycle. An operand of
// zero needs no Euclid step and goes straight to the result.
// The result sits in an output register. The unit accepts a new operand while
// a result still waits on rsp; if rsp stalls until the next result is ready,
// the sequencer holds that result until the register is free.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_unit
    import mie_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    mie_cfg_if.sink     cfg,
    mie_req_if.sink     req,
    mie_rsp_if.source   rsp
);

    localparam logic [WIDTH-1:0] MOD_RST = WIDTH'(MODULUS_RESET);
    localparam logic [WIDTH-1:0] ONE_W   = {{(WIDTH-1){1'b0}}, 1'b1};

    mie_state_t              state_reg, state_next;
    logic [WIDTH-1:0]        modulus_reg;
    logic [WIDTH-1:0]        r_reg, r_next;
    logic [WIDTH-1:0]        nr_reg, nr_next;
    logic signed [WIDTH+1:0] t_reg, t_next;
    logic signed [WIDTH+1:0] nt_reg, nt_next;
    logic                    out_valid_reg, out_valid_next;
    logic [WIDTH-1:0]        inv_reg, inv_next;
    logic                    none_reg, none_next;

    step_ctrl_t              step_ctrl;
    step_stat_t              step_stat;
    logic [WIDTH-1:0]        step_rem;
    logic signed [WIDTH+1:0] step_prod;

    logic signed [WIDTH+1:0] t_lifted;
    logic                    out_free;

    // The modulus register: the channel takes a write in every cycle.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RST;
        end
        else if (cfg.valid)
        begin
            modulus_reg <= cfg.modulus;
        end
    end

    mie_step_unit #(
        .WIDTH     (WIDTH)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (step_ctrl),
        .dividend  (r_reg),
        .divisor   (nr_reg),
        .coef      (nt_reg),
        .stat      (step_stat),
        .remainder (step_rem),
        .product   (step_prod)
    );

    // A negative coefficient is lifted into range by adding the modulus.
    assign t_lifted = t_reg[WIDTH+1] ? (t_reg + $signed({2'b00, modulus_reg})) : t_reg;
    assign out_free = ~out_valid_reg | rsp.ready;

    always_comb
    begin
        state_next      = state_reg;
        r_next          = r_reg;
        nr_next         = nr_reg;
        t_next          = t_reg;
        nt_next         = nt_reg;
        inv_next        = inv_reg;
        none_next       = none_reg;
        out_valid_next  = out_valid_reg & ~rsp.ready;
        step_ctrl.start = 1'b0;
        req.ready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    r_next     = modulus_reg;
                    nr_next    = req.operand;
                    t_next     = '0;
                    nt_next    = {{(WIDTH+1){1'b0}}, 1'b1};
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                // The loop ends when the second remainder reaches zero.
                if (nr_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_ctrl.start = 1'b1;
                    state_next      = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_stat.done)
                begin
                    r_next     = nr_reg;
                    nr_next    = step_rem;
                    t_next     = nt_reg;
                    nt_next    = t_reg - step_prod;
                    state_next = ST_LOOP;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if ((modulus_reg == '0) || (r_reg > ONE_W))
                    begin
                        inv_next  = '0;
                        none_next = 1'b1;
                    end
                    else if (modulus_reg == ONE_W)
                    begin
                        // Every value is congruent to zero modulo one.
                        inv_next  = '0;
                        none_next = 1'b0;
                    end
                    else
                    begin
                        inv_next  = t_lifted[WIDTH-1:0];
                        none_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        nr_reg   <= nr_next;
        t_reg    <= t_next;
        nt_reg   <= nt_next;
        inv_reg  <= inv_next;
        none_reg <= none_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.inverse    = inv_reg;
    assign rsp.no_inverse = none_reg;

endmodule

@@ dv/tb_modular_inverse_ext_euclid_unit.sv @@
// ----------------------------------------------------------------------------
// tb_modular_inverse_ext_euclid_unit: self-checking bench for the inverse unit
// Drives operands through the request channel in random bursts and checks
// every response against an extended Euclid predictor. The bench runs a
// sequence of modulus settings and writes the modulus only while the unit is
// idle. The response side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_modular_inverse_ext_euclid_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import mie_pkg::*;

    localparam int WIDTH = WIDTH_DEFAULT;

    // The drain wait at the end covers one full transaction, and the watchdog
    // allows several times the worst quiet stretch: longest sender gap, longest
    // operand latency and longest response stall back to back.
    localparam int DRAIN_CYCLES = 450;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_PHASES = 12;
    localparam int RANDOM_PER_PHASE = 125;

    // Corner operands for the reset modulus of 2048: zero, one, values next
    // to the modulus, multiples of it, all ones, alternating bit patterns.
    localparam logic [WIDTH-1:0] CORNER_OPS_2048 [15] = '{
        16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h07FF,
        16'h0800, 16'h0801, 16'h1000, 16'h1800, 16'hFFFF,
        16'hFFFE, 16'h8000, 16'h5555, 16'hAAAA, 16'h03FF
    };

    // Corner operands for the largest prime modulus that fits in 16 bits.
    localparam logic [WIDTH-1:0] CORNER_OPS_PRIME [6] = '{
        16'h0000, 16'h0001, 16'hFFF0, 16'hFFF1, 16'hFFF2, 16'hFFFF
    };

    // Corner operands for the modulus two, the smallest one the bench writes.
    localparam logic [WIDTH-1:0] CORNER_OPS_TWO [3] = '{
        16'h0000, 16'h0001, 16'hFFFF
    };

    typedef struct packed {
        logic [WIDTH-1:0] inverse;
        logic             no_inverse;
    } inverse_result_t;

    // Clock, reset and the bench side of every channel. All of them start at
    // a known value so the unit never sees an unknown input.
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic [WIDTH-1:0] req_operand = '0;
    logic             rsp_ready = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [WIDTH-1:0] cfg_modulus = '0;

    mie_cfg_if #(.WIDTH(WIDTH)) cfg_ch ();
    mie_req_if #(.WIDTH(WIDTH)) req_ch ();
    mie_rsp_if #(.WIDTH(WIDTH)) rsp_ch ();

    assign cfg_ch.valid   = cfg_valid;
    assign cfg_ch.modulus = cfg_modulus;
    assign req_ch.valid   = req_valid;
    assign req_ch.operand = req_operand;
    assign rsp_ch.ready   = rsp_ready;

    modular_inverse_ext_euclid_unit #(
        .WIDTH (WIDTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Operands waiting to be sent, and the inverses predicted for operands
    // that the unit has already taken.
    logic [WIDTH-1:0] operand_backlog [$];
    inverse_result_t  pending_inverses [$];

    // Modulus as the bench believes the unit holds it.
    logic [WIDTH-1:0] tracked_modulus = WIDTH'(MODULUS_RESET);

    int  error_count = 0;
    bit  quiet_mode = 1'b0;
    int  burst_left = 1;
    int  gap_left = 0;
    bit  rsp_open = 1'b0;
    int  rsp_run = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Extended Euclid on the remainder pair (modulus, operand) with the
    // Bezout coefficient pair (0, 1). Signed 64-bit arithmetic keeps the
    // coefficients exact for any 16-bit pair.
    function automatic inverse_result_t compute_inverse(logic [WIDTH-1:0] value,
                                                        logic [WIDTH-1:0] q);
        longint          r;
        longint          nr;
        longint          t;
        longint          nt;
        longint          quo;
        longint          rem;
        longint          nxt;
        inverse_result_t res;
        res.inverse = '0;
        res.no_inverse = 1'b1;
        if (q == 0)
        begin
            return res;
        end
        r = longint'(q);
        nr = longint'(value);
        t = 0;
        nt = 1;
        while (nr != 0)
        begin
            quo = r / nr;
            rem = r - quo * nr;
            nxt = t - quo * nt;
            r = nr;
            nr = rem;
            t = nt;
            nt = nxt;
        end
        // A gcd above one means operand and modulus share a factor.
        if (r > 1)
        begin
            return res;
        end
        if (t < 0)
        begin
            t += longint'(q);
        end
        res.inverse = WIDTH'(t % longint'(q));
        res.no_inverse = 1'b0;
        return res;
    endfunction

    // Random operand for modulus q. Half are uniform over the whole field,
    // the rest aim at the interesting regions: below the modulus, exact
    // multiples of it, values right next to it, and values that carry a
    // small factor so that even moduli often have no inverse.
    function automatic logic [WIDTH-1:0] pick_operand(logic [WIDTH-1:0] q);
        int sel;
        int d;
        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            return WIDTH'($urandom_range(0, 65535));
        end
        else if (sel < 70)
        begin
            return WIDTH'($urandom_range(0, int'(q) - 1));
        end
        else if (sel < 80)
        begin
            return WIDTH'($urandom_range(0, 65535 / int'(q)) * int'(q));
        end
        else if (sel < 90)
        begin
            return WIDTH'(int'(q) + int'($urandom_range(0, 4)) - 2);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: d = 2;
                1: d = 3;
                2: d = 5;
                default: d = 7;
            endcase
            return WIDTH'($urandom_range(1, 65535 / d) * d);
        end
    endfunction

    // Gap between sender bursts. Most gaps are short, a few are long enough
    // to land anywhere inside the unit's Euclid loop.
    function automatic int pick_gap();
        int sel;
        if (quiet_mode)
        begin
            return 0;
        end
        sel = $urandom_range(0, 99);
        if (sel < 40)
        begin
            return 0;
        end
        else if (sel < 80)
        begin
            return $urandom_range(1, 8);
        end
        else if (sel < 95)
        begin
            return $urandom_range(9, 60);
        end
        else
        begin
            return $urandom_range(100, 500);
        end
    endfunction

    // Length of a response stall. The longest ones outlast a whole operand,
    // so the unit has to hold a finished result behind the waiting one.
    function automatic int pick_stall();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            return $urandom_range(1, 10);
        end
        else if (sel < 90)
        begin
            return $urandom_range(11, 80);
        end
        else
        begin
            return $urandom_range(200, 600);
        end
    endfunction

    // Request driver. It presents the oldest operand of the backlog and holds
    // it until the transaction completes. After each transaction the burst
    // count drops; an empty burst starts a random gap and a fresh burst.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        logic fire;
        fire = req_valid && req_ch.ready;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                void'(operand_backlog.pop_front());
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 8);
                    gap_left = pick_gap();
                end
            end
            else if (!req_valid && gap_left > 0)
            begin
                gap_left--;
            end
            if (gap_left == 0 && operand_backlog.size() > 0)
            begin
                req_valid <= 1'b1;
                req_operand <= operand_backlog[0];
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Response ready pattern: alternating open and stalled runs of random
    // length. In quiet phases the channel stays open all the time.
    always @(posedge clk or negedge rst_n)
    begin : response_stall
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_run <= 0)
            begin
                rsp_open = !rsp_open;
                rsp_run = rsp_open ? $urandom_range(1, 40) : pick_stall();
            end
            rsp_run--;
            rsp_ready <= quiet_mode || rsp_open;
        end
    end

    // Monitor and scoreboard. Every response transaction is checked against
    // the oldest prediction; every request transaction adds a prediction
    // built from the modulus that was in force when the operand was taken.
    always @(posedge clk)
    begin : result_check
        inverse_result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ready)
            begin
                if (pending_inverses.size() == 0)
                begin
                    $display("%0t: unexpected result inverse=%0d no_inverse=%0b",
                             $time, rsp_ch.inverse, rsp_ch.no_inverse);
                    error_count++;
                end
                else
                begin
                    want = pending_inverses.pop_front();
                    if (rsp_ch.inverse !== want.inverse)
                    begin
                        $display("%0t: inverse mismatch expected=%0d actual=%0d",
                                 $time, want.inverse, rsp_ch.inverse);
                        error_count++;
                    end
                    if (rsp_ch.no_inverse !== want.no_inverse)
                    begin
                        $display("%0t: no_inverse mismatch expected=%0b actual=%0b",
                                 $time, want.no_inverse, rsp_ch.no_inverse);
                        error_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ch.ready)
            begin
                tracked_modulus = cfg_modulus;
            end
            if (req_valid && req_ch.ready)
            begin
                pending_inverses.insert(pending_inverses.size(),
                                        compute_inverse(req_operand, tracked_modulus));
            end
        end
    end

    // Watchdog. Any transaction on any channel counts as progress; a long
    // stretch without one means the unit has hung.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready)
                || (cfg_valid && cfg_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("tb_modular_inverse_ext_euclid_unit: FAIL");
        $finish;
    end

    // Waits until every operand has been sent and every result has come back.
    // Since each operand yields exactly one result, the unit is idle then.
    task automatic wait_for_idle();
        do
        begin
            @(negedge clk);
        end
        while (operand_backlog.size() != 0 || req_valid || pending_inverses.size() != 0);
    endtask

    // One write transaction on the configuration channel.
    task automatic write_modulus(logic [WIDTH-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_modulus <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus sequence. The first phase runs on the reset modulus, later
    // phases each start with a modulus write while the unit is idle. The
    // settings cover the moduli two and 65535, a large prime, even
    // and odd values and random ones. Two phases run with no idling at all.
    initial
    begin : stimulus
        logic [WIDTH-1:0] phase_modulus [NUM_PHASES];
        phase_modulus[0]  = WIDTH'(MODULUS_RESET);
        phase_modulus[1]  = 16'd65521;
        phase_modulus[2]  = 16'd2;
        phase_modulus[3]  = 16'd65535;
        phase_modulus[4]  = 16'd3;
        phase_modulus[5]  = 16'd65534;
        phase_modulus[6]  = 16'd97;
        phase_modulus[7]  = WIDTH'($urandom_range(2, 65535));
        phase_modulus[8]  = WIDTH'($urandom_range(2, 300));
        phase_modulus[9]  = WIDTH'($urandom_range(2, 65535));
        phase_modulus[10] = 16'd256;
        phase_modulus[11] = WIDTH'($urandom_range(2, 65535));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            // The reset value stands for the first phase; every later one
            // writes its own modulus first.
            if (phase != 0)
            begin
                wait_for_idle();
                write_modulus(phase_modulus[phase]);
            end
            quiet_mode = (phase == 3) || (phase == 8);

            // Directed corner operands lead the first three phases.
            if (phase == 0)
            begin
                foreach (CORNER_OPS_2048[i])
                    operand_backlog.insert(operand_backlog.size(), CORNER_OPS_2048[i]);
            end
            else if (phase == 1)
            begin
                foreach (CORNER_OPS_PRIME[i])
                    operand_backlog.insert(operand_backlog.size(), CORNER_OPS_PRIME[i]);
            end
            else if (phase == 2)
            begin
                foreach (CORNER_OPS_TWO[i])
                    operand_backlog.insert(operand_backlog.size(), CORNER_OPS_TWO[i]);
            end

            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                operand_backlog.insert(operand_backlog.size(),
                                       pick_operand(phase_modulus[phase]));
            end
        end

        // Let the last results arrive, then give the unit one more full
        // transaction time to show any stray result.
        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb_modular_inverse_ext_euclid_unit: PASS");
        end
        else
        begin
            $display("tb_modular_inverse_ext_euclid_unit: FAIL");
        end
        $finish;
    end

endmodule
